### sv/mrpd_pkg.sv
// Shared types, codes and decode helpers for the Modbus response PDU decoder.
// Used by the front, queue, back and top-level modules. No dependencies.
`timescale 1ns / 1ps

package mrpd_pkg;

   // Result item kinds.
   localparam logic [1:0] KIND_BIT = 2'd0;
   localparam logic [1:0] KIND_REG = 2'd1;
   localparam logic [1:0] KIND_SUM = 2'd2;

   // Summary status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_EXCEPTION   = 2'd1;
   localparam logic [1:0] ST_BAD_LENGTH  = 2'd2;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

   // Data tables.
   localparam logic [1:0] TBL_COILS    = 2'd0;
   localparam logic [1:0] TBL_DISCRETE = 2'd1;
   localparam logic [1:0] TBL_INPUT    = 2'd2;
   localparam logic [1:0] TBL_HOLDING  = 2'd3;

   // Function codes.
   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
   localparam logic [7:0] FC_READ_WRITE    = 8'd23;

   // Single-coil echo values.
   localparam logic [15:0] COIL_ON       = 16'hFF00;
   localparam logic [15:0] COIL_OFF      = 16'h0000;
   localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic        emit_bits;    // expand stream_word[7:0] into eight bit items
      logic        emit_reg;     // one register item
      logic        has_sum;      // summary item follows the streamed items
      logic [10:0] base_idx;
      logic [15:0] stream_word;
      logic [1:0]  stream_tbl;
      logic [15:0] stream_cnt;
      logic [15:0] sum_val;
      logic [1:0]  sum_tbl;
      logic [15:0] sum_addr;
      logic [15:0] sum_cnt;
      logic [1:0]  sum_status;
   } mrpd_cmd_type;

   function automatic logic [1:0] table_of(input logic [7:0] fc);
      logic [1:0] tbl;
      tbl = TBL_COILS;
      if (fc == FC_READ_DISCRETE) tbl = TBL_DISCRETE;
      else if (fc == FC_READ_INPUT) tbl = TBL_INPUT;
      else if (fc inside {FC_READ_HOLDING, FC_WRITE_REG, FC_WRITE_REGS, FC_READ_WRITE})
         tbl = TBL_HOLDING;
      return tbl;
   endfunction

   function automatic logic is_bit_read(input logic [7:0] fc);
      return fc inside {FC_READ_COILS, FC_READ_DISCRETE};
   endfunction

   function automatic logic is_reg_read(input logic [7:0] fc);
      return fc inside {FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE};
   endfunction

endpackage

### sv/mrpd_front.sv
// Front end of the PDU decoder: takes request bytes, tracks the parse state
// and turns each byte that causes results into a work command. Depends on mrpd_pkg.
`timescale 1ns / 1ps

module mrpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output mrpd_pkg::mrpd_cmd_type q_cmd
);
   import mrpd_pkg::*;

   localparam logic [1:0] PH_CODE  = 2'd0;
   localparam logic [1:0] PH_FIRST = 2'd1;
   localparam logic [1:0] PH_BODY  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  fc_ff, fc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] qty_ff, qty_in;
   logic [10:0] idx_ff, idx_in;

   logic         fire;
   logic [1:0]   ph_mid;
   logic [8:0]   total;
   logic [15:0]  coil_v;
   mrpd_cmd_type cmd;

   assign req_stall = q_full;
   assign fire      = req_valid && !req_stall;

   always_comb begin
      phase_in = phase_ff;
      fc_in    = fc_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      pend_in  = pend_ff;
      addr_in  = addr_ff;
      qty_in   = qty_ff;
      idx_in   = idx_ff;
      ph_mid   = phase_ff;
      total    = 9'd0;
      coil_v   = COIL_OFF;
      cmd      = '0;

      if (fire) begin
         case (phase_ff)
            PH_CODE: begin
               fc_in    = req_data_byte;
               count_in = 8'd0;
               seen_in  = 8'd0;
               pend_in  = 8'd0;
               addr_in  = 16'd0;
               qty_in   = 16'd0;
               idx_in   = 11'd0;
               ph_mid   = PH_FIRST;
            end
            PH_FIRST: begin
               count_in = req_data_byte;
               addr_in  = {8'd0, req_data_byte};
               ph_mid   = PH_BODY;
            end
            default: begin
               if (seen_ff == 8'd0) addr_in = {addr_ff[7:0], req_data_byte};
               else if (seen_ff == 8'd1) qty_in = {8'd0, req_data_byte};
               else if (seen_ff == 8'd2) qty_in = {qty_ff[7:0], req_data_byte};

               if (seen_ff < count_ff) begin
                  if (is_bit_read(fc_ff)) begin
                     cmd.emit_bits   = 1'b1;
                     cmd.base_idx    = idx_ff;
                     cmd.stream_word = {8'd0, req_data_byte};
                     cmd.stream_cnt  = {5'd0, count_ff, 3'd0};
                     idx_in          = idx_ff + 11'd8;
                  end else if (is_reg_read(fc_ff)) begin
                     if (!seen_ff[0]) begin
                        pend_in = req_data_byte;
                     end else begin
                        cmd.emit_reg    = 1'b1;
                        cmd.base_idx    = idx_ff;
                        cmd.stream_word = {pend_ff, req_data_byte};
                        cmd.stream_cnt  = {9'd0, count_ff[7:1]};
                        idx_in          = idx_ff + 11'd1;
                     end
                  end
               end
               if (seen_ff != 8'hFF) seen_in = seen_ff + 8'd1;
               ph_mid = PH_BODY;
            end
         endcase
         cmd.stream_tbl = table_of(fc_ff);
         phase_in       = ph_mid;

         if (req_last_byte) begin
            // Summary is judged on the state after this byte.
            cmd.has_sum = 1'b1;
            phase_in    = PH_CODE;
            if (ph_mid == PH_BODY) total = {1'b0, seen_in} + 9'd1;
            if (qty_in[7:0] == BYTE_ALL_ONES) coil_v = COIL_ON;
            if (total >= 9'd4) coil_v = qty_in;

            if (fc_in[7]) begin
               cmd.sum_status = ST_EXCEPTION;
            end else if (is_bit_read(fc_in)) begin
               if (ph_mid != PH_BODY || count_in == 8'd0 || seen_in < count_in) begin
                  cmd.sum_status = ST_BAD_LENGTH;
               end else begin
                  cmd.sum_tbl = table_of(fc_in);
                  cmd.sum_cnt = {5'd0, count_in, 3'd0};
               end
            end else if (is_reg_read(fc_in)) begin
               if (ph_mid != PH_BODY || count_in[0] || seen_in < count_in) begin
                  cmd.sum_status = ST_BAD_LENGTH;
               end else begin
                  cmd.sum_tbl = table_of(fc_in);
                  cmd.sum_cnt = {9'd0, count_in[7:1]};
               end
            end else if (fc_in == FC_WRITE_COIL) begin
               if (total < 9'd3) begin
                  cmd.sum_status = ST_BAD_LENGTH;
               end else begin
                  cmd.sum_val  = {15'd0, coil_v == COIL_ON};
                  cmd.sum_tbl  = TBL_COILS;
                  cmd.sum_addr = addr_in;
                  cmd.sum_cnt  = 16'd1;
               end
            end else if (fc_in == FC_WRITE_REG) begin
               if (total < 9'd4) begin
                  cmd.sum_status = ST_BAD_LENGTH;
               end else begin
                  cmd.sum_val  = qty_in;
                  cmd.sum_tbl  = TBL_HOLDING;
                  cmd.sum_addr = addr_in;
                  cmd.sum_cnt  = 16'd1;
               end
            end else if (fc_in == FC_WRITE_COILS || fc_in == FC_WRITE_REGS) begin
               if (total < 9'd4) begin
                  cmd.sum_status = ST_BAD_LENGTH;
               end else begin
                  cmd.sum_tbl  = table_of(fc_in);
                  cmd.sum_addr = addr_in;
                  cmd.sum_cnt  = qty_in;
               end
            end else begin
               cmd.sum_status = ST_UNSUPPORTED;
            end
         end
      end
   end

   assign q_push = fire && (cmd.emit_bits || cmd.emit_reg || cmd.has_sum);
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CODE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Parse context is reloaded on every function code byte.
   always_ff @(posedge clock) begin
      fc_ff    <= fc_in;
      count_ff <= count_in;
      seen_ff  <= seen_in;
      pend_ff  <= pend_in;
      addr_ff  <= addr_in;
      qty_ff   <= qty_in;
      idx_ff   <= idx_in;
   end

endmodule

### sv/mrpd_queue.sv
// Small register queue of work commands between the front and back ends.
// Depends on mrpd_pkg.
`timescale 1ns / 1ps

module mrpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mrpd_pkg::mrpd_cmd_type push_cmd,
   output logic                  full,
   input  logic                  pop,
   output mrpd_pkg::mrpd_cmd_type head,
   output logic                  empty
);
   import mrpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mrpd_cmd_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

### sv/mrpd_back.sv
// Back end of the PDU decoder: expands each queued command into result items
// and holds them in the output register. Depends on mrpd_pkg.
`timescale 1ns / 1ps

module mrpd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mrpd_pkg::mrpd_cmd_type head,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_item_kind,
   output logic [10:0]           rsp_element_index,
   output logic [15:0]           rsp_word_value,
   output logic [1:0]            rsp_table_type,
   output logic [15:0]           rsp_start_address,
   output logic [15:0]           rsp_value_count,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last_result
);
   import mrpd_pkg::*;

   logic [3:0]  sub_ff, sub_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [10:0] idx_ff, idx_in;
   logic [15:0] word_ff, word_in;
   logic [1:0]  tbl_ff, tbl_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [1:0]  st_ff, st_in;
   logic        last_ff, last_in;

   logic [3:0] stream_n;
   logic [3:0] n_res;
   logic       load;

   assign stream_n = head.emit_bits ? 4'd8 : (head.emit_reg ? 4'd1 : 4'd0);
   assign n_res    = stream_n + {3'd0, head.has_sum};
   assign load     = !q_empty && (!valid_ff || !rsp_stall);
   assign q_pop    = load && (sub_ff == n_res - 4'd1);

   always_comb begin
      if (sub_ff < stream_n) begin
         kind_in = head.emit_bits ? KIND_BIT : KIND_REG;
         idx_in  = head.base_idx + {7'd0, sub_ff};
         word_in = head.emit_bits ? {15'd0, head.stream_word[sub_ff[2:0]]}
                                  : head.stream_word;
         tbl_in  = head.stream_tbl;
         addr_in = 16'd0;
         cnt_in  = head.stream_cnt;
         st_in   = ST_OK;
         last_in = 1'b0;
      end else begin
         kind_in = KIND_SUM;
         idx_in  = 11'd0;
         word_in = head.sum_val;
         tbl_in  = head.sum_tbl;
         addr_in = head.sum_addr;
         cnt_in  = head.sum_cnt;
         st_in   = head.sum_status;
         last_in = 1'b1;
      end

      valid_in = valid_ff;
      sub_in   = sub_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = q_pop ? 4'd0 : sub_ff + 4'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         idx_ff  <= idx_in;
         word_ff <= word_in;
         tbl_ff  <= tbl_in;
         addr_ff <= addr_in;
         cnt_ff  <= cnt_in;
         st_ff   <= st_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_element_index = idx_ff;
   assign rsp_word_value    = word_ff;
   assign rsp_table_type    = tbl_ff;
   assign rsp_start_address = addr_ff;
   assign rsp_value_count   = cnt_ff;
   assign rsp_status        = st_ff;
   assign rsp_last_result   = last_ff;

endmodule

### sv/modbus_response_pdu_decoder.sv
// Modbus response PDU decoder, top level. Each result is registered in the command
// queue and then in the back end's output register before it reaches the rsp ports.
// Throughput: one request byte per cycle while the command queue has room; the
// back end sends one result per cycle while rsp_stall does not hold it, so a coil
// byte becomes eight bit results (and the summary) and a register pair one result.
// Reset: synchronous, active high; clears parse phase, queue and output valid.
`timescale 1ns / 1ps

module modbus_response_pdu_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic [10:0] rsp_element_index,
   output logic [15:0] rsp_word_value,
   output logic [1:0]  rsp_table_type,
   output logic [15:0] rsp_start_address,
   output logic [15:0] rsp_value_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_result
);
   import mrpd_pkg::*;

   // The front end parses each request byte in the cycle it is accepted and,
   // if the byte causes results, pushes one command describing all of them: eight
   // coil or input bits, one register, and/or the closing summary. It only stalls
   // when the command queue is full.
   logic         q_full;
   logic         q_push;
   mrpd_cmd_type q_cmd;

   mrpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   // The queue lets bytes keep flowing while the back end is still spelling
   // out a coil byte or is held by a stalled consumer.
   mrpd_cmd_type q_head;
   logic         q_empty;
   logic         q_pop;

   mrpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // Unless rsp_stall holds it, the back end walks each command one result per
   // cycle into a registered output stage and pops it with its final result.
   mrpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_element_index (rsp_element_index),
      .rsp_word_value    (rsp_word_value),
      .rsp_table_type    (rsp_table_type),
      .rsp_start_address (rsp_start_address),
      .rsp_value_count   (rsp_value_count),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result)
   );

`ifndef SYNTHESIS
   // Only summary items close a response.
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> rsp_item_kind == KIND_SUM)
      else $error("last_result on a non-summary item");

   // Streamed values carry ok status and no address.
   a_stream_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != KIND_SUM |->
         rsp_status == ST_OK && rsp_start_address == 16'd0)
      else $error("streamed item with status or address set");

   // A coil or input bit value is a single bit.
   a_bit_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_BIT |-> rsp_word_value[15:1] == 15'd0)
      else $error("bit item wider than one bit");

   // Queued work reaches the output stage as soon as it is free.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !q_empty && !rsp_stall |=> rsp_valid)
      else $error("queued command not moved to output");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for modbus_response_pdu_decoder: directed PDUs, then random responses.
// It predicts every decoded item, compares results in order and uses types and codes from mrpd_pkg.
`timescale 1ns / 1ps

module tb_top;
   import mrpd_pkg::*;

   // One decoded item as it leaves the rsp channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] index;
      logic [15:0] value;
      logic [1:0]  tbl;
      logic [15:0] addr;
      logic [15:0] count;
      logic [1:0]  status;
      logic        last;
   } pdu_item_type;

   // One row of the directed table. A pinned row carries the summary status
   // that is known by inspection; that summary then replaces the predicted one.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       pinned;
      logic [1:0] pin_status;
   } stim_row_type;

   // Shadow parser phases.
   localparam logic [1:0] AWAIT_CODE  = 2'd0;
   localparam logic [1:0] AWAIT_COUNT = 2'd1;
   localparam logic [1:0] IN_BODY     = 2'd2;

   localparam int N_DIRECTED    = 26;
   localparam int RANDOM_BYTES  = 394;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_item_kind;
   logic [10:0] rsp_element_index;
   logic [15:0] rsp_word_value;
   logic [1:0]  rsp_table_type;
   logic [15:0] rsp_start_address;
   logic [15:0] rsp_value_count;
   logic [1:0]  rsp_status;
   logic        rsp_last_result;

   // Side information that travels with the request payload.
   logic        req_pinned;
   logic [1:0]  req_pin_status;

   // Items the decoder is still owed, oldest first.
   pdu_item_type decoded_items[$];
   int          mismatch_count;

   // Shadow of the parser state.
   logic [1:0]  parse_phase;
   logic [7:0]  code_q;
   logic [7:0]  byte_count_q;
   logic [7:0]  seen_q;
   logic [7:0]  high_byte_q;
   logic [15:0] addr_q;
   logic [15:0] qty_q;
   logic [10:0] index_q;

   // Stimulus control.
   stim_row_type directed_rows[N_DIRECTED];
   logic [7:0]  pdu_bytes[$];
   bit          quiet_sender;
   bit          hold_rsp_req;

   modbus_response_pdu_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_element_index(rsp_element_index),
      .rsp_word_value   (rsp_word_value),
      .rsp_table_type   (rsp_table_type),
      .rsp_start_address(rsp_start_address),
      .rsp_value_count  (rsp_value_count),
      .rsp_status       (rsp_status),
      .rsp_last_result  (rsp_last_result)
   );

   // 20 ns clock period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [1:0] table_for(input logic [7:0] code);
      case (code)
         FC_READ_DISCRETE: return TBL_DISCRETE;
         FC_READ_INPUT:    return TBL_INPUT;
         FC_READ_HOLDING, FC_WRITE_REG, FC_WRITE_REGS, FC_READ_WRITE: return TBL_HOLDING;
         default:          return TBL_COILS;
      endcase
   endfunction

   function automatic pdu_item_type make_item(input logic [1:0] kind, input logic [10:0] index,
                                           input logic [15:0] value, input logic [1:0] tbl,
                                           input logic [15:0] addr, input logic [15:0] count,
                                           input logic [1:0] status, input logic last);
      pdu_item_type it;
      it.kind   = kind;
      it.index  = index;
      it.value  = value;
      it.tbl    = tbl;
      it.addr   = addr;
      it.count  = count;
      it.status = status;
      it.last   = last;
      return it;
   endfunction

   // Advances the shadow parser by one request byte and queues every item it causes.
   task automatic decode_pdu_byte(input logic [7:0] b, input logic last);
      logic [7:0]  k;
      logic [8:0]  total;
      logic [15:0] coil_word;
      logic [1:0]  st;
      logic [15:0] val;
      logic [1:0]  tbl;
      logic [15:0] addr;
      logic [15:0] cnt;
      logic        bit_read;
      logic        reg_read;
      bit_read = (code_q == FC_READ_COILS) || (code_q == FC_READ_DISCRETE);
      reg_read = (code_q == FC_READ_HOLDING) || (code_q == FC_READ_INPUT) ||
                 (code_q == FC_READ_WRITE);
      if (parse_phase == AWAIT_CODE) begin
         // A new response starts: everything from the previous one is dropped.
         code_q       = b;
         byte_count_q = 8'd0;
         seen_q       = 8'd0;
         high_byte_q  = 8'd0;
         addr_q       = 16'd0;
         qty_q        = 16'd0;
         index_q      = 11'd0;
         parse_phase  = AWAIT_COUNT;
         bit_read = (b == FC_READ_COILS) || (b == FC_READ_DISCRETE);
         reg_read = (b == FC_READ_HOLDING) || (b == FC_READ_INPUT) || (b == FC_READ_WRITE);
      end else if (parse_phase == AWAIT_COUNT) begin
         // For reads this is the byte count, for writes the address high byte.
         byte_count_q = b;
         addr_q       = {8'd0, b};
         parse_phase  = IN_BODY;
      end else begin
         k = seen_q;
         if (k == 8'd0) addr_q = {addr_q[7:0], b};
         else if (k == 8'd1) qty_q = {8'd0, b};
         else if (k == 8'd2) qty_q = {qty_q[7:0], b};
         if (k < byte_count_q) begin
            if (bit_read) begin
               for (int j = 0; j < 8; j++) begin
                  decoded_items.push_back(make_item(KIND_BIT, index_q, {15'd0, b[j]},
                     table_for(code_q), 16'd0, {5'd0, byte_count_q, 3'd0}, ST_OK, 1'b0));
                  index_q = index_q + 11'd1;
               end
            end else if (reg_read) begin
               // Registers are big-endian; the low byte completes the pair.
               if (!k[0]) begin
                  high_byte_q = b;
               end else begin
                  decoded_items.push_back(make_item(KIND_REG, index_q, {high_byte_q, b},
                     table_for(code_q), 16'd0, {9'd0, byte_count_q[7:1]}, ST_OK, 1'b0));
                  index_q = index_q + 11'd1;
               end
            end
         end
         if (seen_q != 8'hFF) seen_q = seen_q + 8'd1;
      end

      if (last) begin
         total = (parse_phase == IN_BODY) ? 9'd1 + {1'b0, seen_q} : 9'd0;
         st    = ST_OK;
         val   = 16'd0;
         tbl   = TBL_COILS;
         addr  = 16'd0;
         cnt   = 16'd0;
         if (code_q[7]) begin
            st = ST_EXCEPTION;
         end else if (bit_read) begin
            if (parse_phase != IN_BODY || byte_count_q == 8'd0 || seen_q < byte_count_q) begin
               st = ST_BAD_LENGTH;
            end else begin
               tbl = table_for(code_q);
               cnt = {5'd0, byte_count_q, 3'd0};
            end
         end else if (reg_read) begin
            if (parse_phase != IN_BODY || byte_count_q[0] || seen_q < byte_count_q) begin
               st = ST_BAD_LENGTH;
            end else begin
               tbl = table_for(code_q);
               cnt = {9'd0, byte_count_q[7:1]};
            end
         end else if (code_q == FC_WRITE_COIL) begin
            if (total < 9'd3) begin
               st = ST_BAD_LENGTH;
            end else begin
               // A three-byte echo only carries the high byte of the coil value.
               if (total >= 9'd4) coil_word = qty_q;
               else coil_word = (qty_q[7:0] == BYTE_ALL_ONES) ? COIL_ON : COIL_OFF;
               val  = {15'd0, coil_word == COIL_ON};
               tbl  = TBL_COILS;
               addr = addr_q;
               cnt  = 16'd1;
            end
         end else if (code_q == FC_WRITE_REG) begin
            if (total < 9'd4) begin
               st = ST_BAD_LENGTH;
            end else begin
               val  = qty_q;
               tbl  = TBL_HOLDING;
               addr = addr_q;
               cnt  = 16'd1;
            end
         end else if (code_q == FC_WRITE_COILS || code_q == FC_WRITE_REGS) begin
            if (total < 9'd4) begin
               st = ST_BAD_LENGTH;
            end else begin
               tbl  = table_for(code_q);
               addr = addr_q;
               cnt  = qty_q;
            end
         end else begin
            st = ST_UNSUPPORTED;
         end
         decoded_items.push_back(make_item(KIND_SUM, 11'd0, val, tbl, addr, cnt, st, 1'b1));
         parse_phase = AWAIT_CODE;
      end
   endtask

   task automatic note_fault(input string what, input pdu_item_type want,
                             input pdu_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected kind=%0d idx=%0d val=%h tbl=%0d addr=%h cnt=%0d st=%0d ",
                  $time, what, want.kind, want.index, want.value, want.tbl, want.addr,
                  want.count, want.status,
                  "last=%0d / got kind=%0d idx=%0d val=%h tbl=%0d addr=%h cnt=%0d st=%0d last=%0d",
                  want.last, got.kind, got.index, got.value, got.tbl, got.addr, got.count,
                  got.status, got.last);
   endtask

   // Result checking and request tracking share one process. Both sample
   // the values present just before the edge, so the order against the
   // driving processes does not matter. Results are checked before the
   // request of the same edge is decoded; a result never comes in the
   // cycle its request is taken.
   always @(posedge clock) begin : watch
      pdu_item_type got;
      pdu_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = make_item(rsp_item_kind, rsp_element_index, rsp_word_value, rsp_table_type,
                            rsp_start_address, rsp_value_count, rsp_status, rsp_last_result);
            if (decoded_items.size() == 0) begin
               note_fault("unexpected result", '0, got);
            end else begin
               want = decoded_items.pop_front();
               if (got !== want) note_fault("result mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            decode_pdu_byte(req_data_byte, req_last_byte);
            // A pinned last byte: the summary value is fixed by the table.
            if (req_pinned && req_last_byte) begin
               void'(decoded_items.pop_back());
               decoded_items.push_back(make_item(KIND_SUM, 11'd0, 16'd0, TBL_COILS, 16'd0,
                                                 16'd0, req_pin_status, 1'b1));
            end
         end
      end
   end

   // Most gaps are short, a few long, and quiet responses have none.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_sender || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Offers one request byte and returns at the edge where it is taken.
   // Valid only drops when a gap follows, so it is never lowered and raised
   // within the same step.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                            input logic [1:0] pin_status);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_last_byte  <= last;
      req_pinned     <= pinned;
      req_pin_status <= pin_status;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [7:0] pick_supported();
      case ($urandom_range(0, 8))
         0:       return FC_READ_COILS;
         1:       return FC_READ_DISCRETE;
         2:       return FC_READ_HOLDING;
         3:       return FC_READ_INPUT;
         4:       return FC_WRITE_COIL;
         5:       return FC_WRITE_REG;
         6:       return FC_WRITE_COILS;
         7:       return FC_WRITE_REGS;
         default: return FC_READ_WRITE;
      endcase
   endfunction

   // Builds one random response into pdu_bytes. Most are well-formed with
   // random content; some are broken (cut short, bad count, exception bit)
   // and a few are pure noise with an arbitrary code.
   task automatic compose_response();
      int pick;
      int n;
      int cut;
      logic [7:0] code;
      pdu_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
         pdu_bytes.push_back(8'($urandom));
         n = $urandom_range(0, 5);
         repeat (n) pdu_bytes.push_back(8'($urandom));
      end else begin
         code = pick_supported();
         pdu_bytes.push_back(code);
         if (code == FC_READ_COILS || code == FC_READ_DISCRETE) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            pdu_bytes.push_back(8'(n));
            repeat (n) pdu_bytes.push_back(8'($urandom));
         end else if (code == FC_READ_HOLDING || code == FC_READ_INPUT ||
                      code == FC_READ_WRITE) begin
            n = 2 * $urandom_range(1, 4);
            pdu_bytes.push_back(8'(n));
            repeat (n) pdu_bytes.push_back(8'($urandom));
         end else if (code == FC_WRITE_COIL) begin
            repeat (2) pdu_bytes.push_back(8'($urandom));
            case ($urandom_range(0, 2))
               0: begin
                  pdu_bytes.push_back(COIL_ON[15:8]);
                  pdu_bytes.push_back(COIL_ON[7:0]);
               end
               1: begin
                  pdu_bytes.push_back(COIL_OFF[15:8]);
                  pdu_bytes.push_back(COIL_OFF[7:0]);
               end
               default: repeat (2) pdu_bytes.push_back(8'($urandom));
            endcase
         end else begin
            repeat (4) pdu_bytes.push_back(8'($urandom));
         end
         // Trailing bytes past the count are to be ignored.
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2))
            pdu_bytes.push_back(8'($urandom));
         if (pick >= 75) begin
            case ($urandom_range(0, 2))
               0: begin
                  cut = $urandom_range(1, pdu_bytes.size() - 1);
                  while (pdu_bytes.size() > cut) void'(pdu_bytes.pop_back());
               end
               1:       pdu_bytes[1] = 8'($urandom);
               default: pdu_bytes[0] = pdu_bytes[0] | 8'h80;
            endcase
         end
      end
   endtask

   // Waits until every owed item has arrived, then lets the pipeline settle.
   task automatic wait_for_results();
      int waited;
      waited = 0;
      while (decoded_items.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side back-pressure: random runs of stall, mostly short, now and
   // then a long quiet stretch, and one long hold on request so that the
   // command queue fills and the decoder stalls its request side.
   initial begin : rsp_sink
      int r;
      int len;
      logic stall_val;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            stall_val    = 1'b1;
            len          = HOLD_CYCLES;
         end else if (r < 55) begin
            stall_val = 1'b0;
            len       = $urandom_range(1, 8);
         end else if (r < 65) begin
            stall_val = 1'b0;
            len       = $urandom_range(30, 60);
         end else if (r < 92) begin
            stall_val = 1'b1;
            len       = $urandom_range(1, 3);
         end else begin
            stall_val = 1'b1;
            len       = $urandom_range(8, 20);
         end
         rsp_stall <= stall_val;
         repeat (len) @(posedge clock);
      end
   end

   // Main sequence: reset, directed table, random responses, final check.
   initial begin : stimulus
      int sent_random;
      bit drained_midway;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'd0;
      req_last_byte  = 1'b0;
      req_pinned     = 1'b0;
      req_pin_status = ST_OK;
      mismatch_count = 0;
      quiet_sender   = 1'b0;
      hold_rsp_req   = 1'b0;
      sent_random    = 0;
      drained_midway = 1'b0;
      parse_phase    = AWAIT_CODE;
      code_q         = 8'd0;
      byte_count_q   = 8'd0;
      seen_q         = 8'd0;
      high_byte_q    = 8'd0;
      addr_q         = 16'd0;
      qty_q          = 16'd0;
      index_q        = 11'd0;

      // Each response is one group of rows; the last row carries the mark.
      directed_rows = '{
         // Exception reply: the data byte is ignored.
         '{8'h83, 1'b0, 1'b0, ST_OK}, '{8'h02, 1'b1, 1'b1, ST_EXCEPTION},
         // Code zero, alone: unsupported.
         '{8'h00, 1'b1, 1'b1, ST_UNSUPPORTED},
         // Read reply that ends on its code byte.
         '{8'h17, 1'b1, 1'b1, ST_BAD_LENGTH},
         // Bit read with a byte count of zero.
         '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_BAD_LENGTH},
         // One coil byte and a trailing byte past the count.
         '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK},
         '{8'hA5, 1'b0, 1'b0, ST_OK}, '{8'h3C, 1'b1, 1'b0, ST_OK},
         // Odd register count: one full pair streams, the summary is bad length.
         '{8'h03, 1'b0, 1'b0, ST_OK}, '{8'h03, 1'b0, 1'b0, ST_OK},
         '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
         '{8'h00, 1'b1, 1'b1, ST_BAD_LENGTH},
         // Short single-coil echo with the on value.
         '{8'h05, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
         '{8'h10, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b1, 1'b0, ST_OK},
         // Single register write cut one byte short.
         '{8'h06, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
         '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b1, 1'b1, ST_BAD_LENGTH},
         // Register read with fewer data bytes than declared.
         '{8'h04, 1'b0, 1'b0, ST_OK}, '{8'h04, 1'b0, 1'b0, ST_OK},
         '{8'h12, 1'b1, 1'b1, ST_BAD_LENGTH}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pinned,
                   directed_rows[i].pin_status);

      // The receiver goes quiet for a long stretch while requests keep coming.
      hold_rsp_req = 1'b1;
      while (sent_random < RANDOM_BYTES) begin
         compose_response();
         quiet_sender = ($urandom_range(0, 3) == 0) || (sent_random < 40);
         foreach (pdu_bytes[i])
            send_byte(pdu_bytes[i], i == pdu_bytes.size() - 1, 1'b0, ST_OK);
         sent_random += pdu_bytes.size();
         // Halfway through, the sender pauses until all results are in.
         if (!drained_midway && sent_random >= RANDOM_BYTES / 2) begin
            drained_midway = 1'b1;
            req_valid <= 1'b0;
            wait_for_results();
         end
      end
      req_valid <= 1'b0;

      wait_for_results();
      // Results that never arrived count as mismatches.
      mismatch_count += decoded_items.size();
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin : watchdog
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
